[hw/rtl/calendar_date_register_assert.svh]
// ----------------------------------------------------------------------------
// calendar date register assertion macros
// concurrent checks on the clk / rst_n domain of the including module
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_REGISTER_ASSERT_SVH
`define CALENDAR_DATE_REGISTER_ASSERT_SVH

// same-cycle implication
`define CDR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cdr_pkg.sv]
// ----------------------------------------------------------------------------
// cdr_pkg
// shared types, codes and calendar helpers of the calendar date register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdr_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned AMT_W   = 12;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned IDX_W   = 2;

  localparam logic [AMT_W-1:0]  MAX_DAY_STEP = 12'd30;
  localparam logic [YEAR_W:0]   YEAR_MAX     = 15'd9999;

  // reciprocal of twelve, exact for dividends below 8192
  localparam logic [12:0] DIV12_MUL   = 13'd5462;
  localparam int unsigned DIV12_SHIFT = 16;

  localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;
  localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
  localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2012;

  localparam logic [IDX_W-1:0] CFG_IDX_DEFAULT_DAY   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IDX_DEFAULT_MONTH = 2'd1;
  localparam logic [IDX_W-1:0] CFG_IDX_DEFAULT_YEAR  = 2'd2;

  typedef enum logic [1:0] {
    CMD_SET       = 2'd0,
    CMD_ADD_DAY   = 2'd1,
    CMD_ADD_MONTH = 2'd2,
    CMD_ADD_YEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DATE  = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [DAY_W-1:0]   default_day;
    logic [MONTH_W-1:0] default_month;
    logic [YEAR_W-1:0]  default_year;
  } cfg_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [DAY_W-1:0]   set_day;
    logic [MONTH_W-1:0] set_month;
    logic [YEAR_W-1:0]  set_year;
    logic [AMT_W-1:0]   amount;
  } item_t;

  // month length, simplified leap rule; out-of-range months read as 31
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic [1:0] y_lsb);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = (y_lsb == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cdr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cdr_cfg_regs
// default date registers loaded through the write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdr_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [cdr_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [cdr_pkg::CFG_W-1:0] cfg_wdata,
  output cdr_pkg::cfg_t                  cfg
);
  import cdr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_DEFAULT_DAY:   cfg_nxt.default_day   = cfg_wdata[DAY_W-1:0];
        CFG_IDX_DEFAULT_MONTH: cfg_nxt.default_month = cfg_wdata[MONTH_W-1:0];
        CFG_IDX_DEFAULT_YEAR:  cfg_nxt.default_year  = cfg_wdata[YEAR_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_day   <= RST_DAY;
      cfg_r.default_month <= RST_MONTH;
      cfg_r.default_year  <= RST_YEAR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hw/rtl/cdr_date_calc.sv]
// ----------------------------------------------------------------------------
// cdr_date_calc
// combinational date update for one command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdr_date_calc (
  input  wire cdr_pkg::item_t item,
  input  wire cdr_pkg::date_t cur,
  input  wire cdr_pkg::cfg_t  cfg,
  output cdr_pkg::date_t   nxt,
  output cdr_pkg::status_t status
);
  import cdr_pkg::*;

  // set
  logic [DAY_W-1:0]   s_day;
  logic [MONTH_W-1:0] s_month;
  logic [YEAR_W-1:0]  s_year;
  logic               s_ok;

  // add days, four month carries at most
  logic [DAY_W:0]     ad_day;
  logic [MONTH_W-1:0] ad_month;
  logic [YEAR_W:0]    ad_year;
  logic               ad_done;
  logic [DAY_W-1:0]   ad_len;

  // add months
  logic [12:0]        am_total;
  logic [25:0]        am_prod;
  logic [8:0]         am_q;
  logic [12:0]        am_q12;
  logic [MONTH_W-1:0] am_rem;
  logic [YEAR_W:0]    am_year;

  // add years
  logic [YEAR_W:0]    ay_year;

  always_comb begin
    s_day   = (item.set_day   == '0) ? cfg.default_day   : item.set_day;
    s_month = (item.set_month == '0) ? cfg.default_month : item.set_month;
    s_year  = (item.set_year  == '0) ? cfg.default_year  : item.set_year;
    s_ok    = (s_month != '0) && (s_month <= 4'd12) &&
              (s_year != '0) && ({1'b0, s_year} <= YEAR_MAX) &&
              (s_day != '0) && (s_day <= days_in(s_month, s_year[1:0]));
  end

  always_comb begin
    ad_day   = {1'b0, cur.day} + (DAY_W+1)'(item.amount[5:0]);
    ad_month = cur.month;
    ad_year  = {1'b0, cur.year};
    ad_done  = 1'b0;
    ad_len   = '0;
    for (int k = 0; k < 4; k++) begin
      ad_len = days_in(ad_month, ad_year[1:0]);
      if (!ad_done) begin
        if (ad_day <= {1'b0, ad_len}) begin
          ad_done = 1'b1;
        end else begin
          ad_day = ad_day - {1'b0, ad_len};
          if (ad_month >= 4'd12) begin
            ad_month = 4'd1;
            ad_year  = ad_year + 15'd1;
          end else begin
            ad_month = ad_month + 4'd1;
          end
        end
      end
    end
  end

  always_comb begin
    am_total = 13'(cur.month - 4'd1) + {1'b0, item.amount};
    am_prod  = {13'b0, am_total} * {13'b0, DIV12_MUL};
    am_q     = am_prod[DIV12_SHIFT+8:DIV12_SHIFT];
    am_q12   = {1'b0, am_q, 3'b000} + {2'b00, am_q, 2'b00};
    am_rem   = 4'(am_total - am_q12);
    am_year  = {1'b0, cur.year} + {6'b0, am_q};
  end

  assign ay_year = {1'b0, cur.year} + {3'b0, item.amount};

  always_comb begin
    nxt    = cur;
    status = ST_OK;
    unique case (item.cmd)
      CMD_SET: begin
        if (s_ok) begin
          nxt.day   = s_day;
          nxt.month = s_month;
          nxt.year  = s_year;
        end else begin
          status = ST_BAD_DATE;
        end
      end
      CMD_ADD_DAY: begin
        if (item.amount > MAX_DAY_STEP) begin
          status = ST_TOO_LARGE;
        end else if (ad_year > YEAR_MAX) begin
          status = ST_OVERFLOW;
        end else begin
          nxt.day   = ad_day[DAY_W-1:0];
          nxt.month = ad_month;
          nxt.year  = ad_year[YEAR_W-1:0];
        end
      end
      CMD_ADD_MONTH: begin
        if (am_year > YEAR_MAX) begin
          status = ST_OVERFLOW;
        end else begin
          nxt.month = am_rem + 4'd1;
          nxt.year  = am_year[YEAR_W-1:0];
        end
      end
      CMD_ADD_YEAR: begin
        if (ay_year > YEAR_MAX) begin
          status = ST_OVERFLOW;
        end else begin
          if (cur.day == 5'd29 && cur.month == 4'd2 && ay_year[1:0] != 2'b00) begin
            nxt.day   = 5'd1;
            nxt.month = 4'd3;
          end
          nxt.year = ay_year[YEAR_W-1:0];
        end
      end
      default: begin
        nxt    = cur;
        status = ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/calendar_date_register.sv]
// ----------------------------------------------------------------------------
// calendar_date_register
// holds one calendar date and applies set / add-day / add-month / add-year
// commands, one result transaction per command
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, cmd, set_*, amount   | to block
//   out     | out_valid/out_ready, cur_*, status      | from block
//   cfg     | cfg_we, cfg_index, cfg_wdata            | to block
//
// one transaction per cycle sustained while results are taken; a result is
// registered in the date register once its command has left the input
// register, through the combinational update logic
// rst_n is synchronous: date resets to 1 january 2012, defaults to the same
// an output stall holds the date register; the input register keeps taking
// one more transaction, then in_ready drops until the result is taken
//
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_date_register_assert.svh"

module calendar_date_register (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // command channel
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [cdr_pkg::DAY_W-1:0]   in_set_day,
  input  wire logic [cdr_pkg::MONTH_W-1:0] in_set_month,
  input  wire logic [cdr_pkg::YEAR_W-1:0]  in_set_year,
  input  wire logic [cdr_pkg::AMT_W-1:0]   in_amount,
  // result channel
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [cdr_pkg::DAY_W-1:0]   out_cur_day,
  output      logic [cdr_pkg::MONTH_W-1:0] out_cur_month,
  output      logic [cdr_pkg::YEAR_W-1:0]  out_cur_year,
  output      logic [1:0]                  out_status,
  // configuration write port
  input  wire logic                        cfg_we,
  input  wire logic [cdr_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [cdr_pkg::CFG_W-1:0]   cfg_wdata
);
  import cdr_pkg::*;

  cfg_t    cfg;

  // input register stage
  logic    in_valid_r;
  item_t   item_r;

  // date register doubles as the result payload
  date_t   date_r;
  date_t   date_nxt;
  status_t status_r;
  status_t status_nxt;
  logic    out_valid_r;

  logic    advance;

  cdr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cdr_date_calc u_calc (
    .item   (item_r),
    .cur    (date_r),
    .cfg    (cfg),
    .nxt    (date_nxt),
    .status (status_nxt)
  );

  // a held command moves on once the result slot is empty or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.cmd       <= cmd_t'(in_cmd);
      item_r.set_day   <= in_set_day;
      item_r.set_month <= in_set_month;
      item_r.set_year  <= in_set_year;
      item_r.amount    <= in_amount;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      date_r.day   <= RST_DAY;
      date_r.month <= RST_MONTH;
      date_r.year  <= RST_YEAR;
      status_r     <= ST_OK;
      out_valid_r  <= 1'b0;
    end else if (advance) begin
      date_r      <= date_nxt;
      status_r    <= status_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cur_day   = date_r.day;
  assign out_cur_month = date_r.month;
  assign out_cur_year  = date_r.year;
  assign out_status    = status_r;

  // stored month never leaves 1..12
  `CDR_ASSERT_IMPL(a_month_range, 1'b1,
                   date_r.month >= 4'd1 && date_r.month <= 4'd12, "stored month out of range")
  // stored year never leaves 1..9999
  `CDR_ASSERT_IMPL(a_year_range, 1'b1,
                   date_r.year != '0 && {1'b0, date_r.year} <= YEAR_MAX,
                   "stored year out of range")
  // a failing command leaves the date untouched
  `CDR_ASSERT_NEXT(a_fail_keeps_date, advance && status_nxt != ST_OK,
                   date_r == $past(date_r), "failed command changed the date")
  // a draining consumer never blocks the command side
  `CDR_ASSERT_IMPL(a_no_bubble, out_ready, in_ready, "in_ready low while results drain")

endmodule

`default_nettype wire

[verif/tb_calendar_date_register.sv]
// ----------------------------------------------------------------------------
// tb_calendar_date_register
// self-checking bench for the calendar date register: a local date predictor
// follows every accepted command transaction, and each result transaction is
// checked field by field under random valid/ready idling and output stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_calendar_date_register;
  import cdr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_LEN    = 64;
  // index with no register behind it; writes to it must change nothing
  localparam logic [IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    status_t            status;
  } date_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_cmd;
  logic [DAY_W-1:0]    in_set_day;
  logic [MONTH_W-1:0]  in_set_month;
  logic [YEAR_W-1:0]   in_set_year;
  logic [AMT_W-1:0]    in_amount;
  logic                out_valid;
  logic                out_ready;
  logic [DAY_W-1:0]    out_cur_day;
  logic [MONTH_W-1:0]  out_cur_month;
  logic [YEAR_W-1:0]   out_cur_year;
  logic [1:0]          out_status;
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;

  // predictor state: the stored date and the set-command defaults
  date_t        cal;
  cfg_t         dflt;
  date_result_t pending_dates[$];

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // hold-off requests from the test process, served by the receiver
  int unsigned hold_asks;
  int unsigned hold_seen;
  int unsigned hold_left;

  calendar_date_register dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_set_day    (in_set_day),
    .in_set_month  (in_set_month),
    .in_set_year   (in_set_year),
    .in_amount     (in_amount),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cur_day   (out_cur_day),
    .out_cur_month (out_cur_month),
    .out_cur_year  (out_cur_year),
    .out_status    (out_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // date predictor
  // ---------------------------------------------------------------------------

  // month length with the divisible-by-four leap rule
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    case (m)
      2:           return (y % 4 == 0) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // applies one command to the predicted date; a failing command keeps it
  function automatic status_t apply_to_date(input item_t it);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned total;
    status_t     st;
    st = ST_OK;
    d = 32'(cal.day);
    m = 32'(cal.month);
    y = 32'(cal.year);
    case (it.cmd)
      CMD_SET: begin
        // zero fields pick up the defaults before any range check
        d = 32'((it.set_day == 0) ? dflt.default_day : it.set_day);
        m = 32'((it.set_month == 0) ? dflt.default_month : it.set_month);
        y = 32'((it.set_year == 0) ? dflt.default_year : it.set_year);
        if (m < 1 || m > 12 || y < 1 || y > 32'(YEAR_MAX) || d < 1 || d > month_days(m, y))
          st = ST_BAD_DATE;
      end
      CMD_ADD_DAY: begin
        if (it.amount > MAX_DAY_STEP) begin
          st = ST_TOO_LARGE;
        end else begin
          d = d + 32'(it.amount);
          // a sum of at most 61 days needs no more than four month carries
          for (int k = 0; k < 4; k++) begin
            if (d > month_days(m, y)) begin
              d = d - month_days(m, y);
              m = m + 1;
              if (m > 12) begin
                m = 1;
                y = y + 1;
              end
            end
          end
          if (y > 32'(YEAR_MAX))
            st = ST_OVERFLOW;
        end
      end
      CMD_ADD_MONTH: begin
        // day is left alone, it may now lie past the end of the month
        total = m - 1 + 32'(it.amount);
        y = y + total / 12;
        m = total % 12 + 1;
        if (y > 32'(YEAR_MAX))
          st = ST_OVERFLOW;
      end
      default: begin
        y = y + 32'(it.amount);
        if (y > 32'(YEAR_MAX)) begin
          st = ST_OVERFLOW;
        end else if (d == 29 && m == 2 && y % 4 != 0) begin
          // leap day slides to the first of march
          d = 1;
          m = 3;
        end
      end
    endcase
    if (st == ST_OK) begin
      cal.day   = d[DAY_W-1:0];
      cal.month = m[MONTH_W-1:0];
      cal.year  = y[YEAR_W-1:0];
    end
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver and result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      // long hold-off so the block fills up and stalls its input
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned want_v,
                               input int unsigned got_v);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : check_result
    date_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_dates.size() == 0) begin
        mismatches++;
        $display("%0t ns: result transaction with nothing expected, actual %0d/%0d/%0d st %0d",
                 $time, out_cur_day, out_cur_month, out_cur_year, out_status);
      end else begin
        want = pending_dates.pop_front();
        if (want.day !== out_cur_day)
          flag_mismatch("day", 32'(want.day), 32'(out_cur_day));
        if (want.month !== out_cur_month)
          flag_mismatch("month", 32'(want.month), 32'(out_cur_month));
        if (want.year !== out_cur_year)
          flag_mismatch("year", 32'(want.year), 32'(out_cur_year));
        if (want.status !== out_status)
          flag_mismatch("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offers one command transaction; valid stays up after acceptance so a
  // following command can go out back to back
  task automatic push_cmd(input item_t it);
    date_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= it.cmd;
    in_set_day   <= it.set_day;
    in_set_month <= it.set_month;
    in_set_year  <= it.set_year;
    in_amount    <= it.amount;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    res.status = apply_to_date(it);
    res.day    = cal.day;
    res.month  = cal.month;
    res.year   = cal.year;
    pending_dates.push_back(res);
  endtask

  // sender pause until every expected result transaction has come back
  task automatic settle_results();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0)
      @(posedge clk);
    // results trail their commands through the input and date registers; a little margin on top
    repeat (3) @(posedge clk);
  endtask

  // register writes only with the block idle
  task automatic write_default(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    settle_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_IDX_DEFAULT_DAY:   dflt.default_day   = val[DAY_W-1:0];
      CFG_IDX_DEFAULT_MONTH: dflt.default_month = val[MONTH_W-1:0];
      CFG_IDX_DEFAULT_YEAR:  dflt.default_year  = val[YEAR_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // unused fields carry random bits so every port bit toggles
  function automatic item_t make_set(input int unsigned d, input int unsigned m,
                                     input int unsigned y);
    item_t it;
    it.cmd       = CMD_SET;
    it.set_day   = d[DAY_W-1:0];
    it.set_month = m[MONTH_W-1:0];
    it.set_year  = y[YEAR_W-1:0];
    it.amount    = 12'($urandom_range(4095));
    return it;
  endfunction

  function automatic item_t make_add(input cmd_t c, input int unsigned amt);
    item_t it;
    it.cmd       = c;
    it.set_day   = 5'($urandom_range(31));
    it.set_month = 4'($urandom_range(15));
    it.set_year  = 14'($urandom_range(16383));
    it.amount    = amt[AMT_W-1:0];
    return it;
  endfunction

  // mostly plausible dates and small amounts, with a tail of wild values
  function automatic item_t random_cmd();
    item_t       it;
    int unsigned r;
    it = make_add(cmd_t'($urandom_range(3)), 0);
    r = $urandom_range(99);
    case (it.cmd)
      CMD_SET: begin
        if (r < 25) begin
          // leap day territory
          it.set_month = 4'd2;
          it.set_day   = 5'($urandom_range(28, 31));
        end else begin
          it.set_day   = (r < 30) ? 5'd0 : 5'($urandom_range(1, 31));
          it.set_month = (r < 35) ? 4'd0 : (r < 42) ? 4'($urandom_range(13, 15))
                                                      : 4'($urandom_range(1, 12));
        end
        r = $urandom_range(99);
        if (r < 5)       it.set_year = 14'd0;
        else if (r < 10) it.set_year = 14'($urandom_range(16383));
        else if (r < 15) it.set_year = 14'($urandom_range(1, 4));
        else if (r < 20) it.set_year = 14'($urandom_range(9990, 9999));
        else             it.set_year = 14'($urandom_range(1, 9999));
      end
      CMD_ADD_DAY: begin
        if (r < 85)      it.amount = 12'($urandom_range(32'(MAX_DAY_STEP)));
        else if (r < 93) it.amount = 12'($urandom_range(31, 40));
        else             it.amount = 12'($urandom_range(4095));
      end
      CMD_ADD_MONTH: begin
        if (r < 80) it.amount = 12'($urandom_range(24));
        else        it.amount = 12'($urandom_range(4095));
      end
      default: begin
        if (r < 80)      it.amount = 12'($urandom_range(8));
        else if (r < 90) it.amount = 12'($urandom_range(400));
        else             it.amount = 12'($urandom_range(4095));
      end
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // date and defaults straight out of reset
  task automatic test_reset_date();
    push_cmd(make_add(CMD_ADD_DAY, 0));
    push_cmd(make_set(0, 0, 0));
  endtask

  task automatic test_set_extremes();
    push_cmd(make_set(31, 12, 9999));
    push_cmd(make_set(29, 2, 2013));   // no leap day in a non-leap year
    push_cmd(make_set(29, 2, 2012));
    push_cmd(make_set(31, 4, 2000));   // day past a 30-day month
    push_cmd(make_set(1, 13, 2000));
    push_cmd(make_set(1, 15, 2000));
    push_cmd(make_set(1, 1, 16383));   // year beyond 9999
    push_cmd(make_set(31, 1, 1));
  endtask

  task automatic test_add_extremes();
    push_cmd(make_add(CMD_ADD_DAY, 31));      // just above the day step
    push_cmd(make_add(CMD_ADD_DAY, 4095));
    push_cmd(make_add(CMD_ADD_MONTH, 1));     // 31 february, day kept
    push_cmd(make_add(CMD_ADD_DAY, 0));       // zero amount still normalizes
    push_cmd(make_add(CMD_ADD_MONTH, 11));    // back to 3 february of year 2
    push_cmd(make_add(CMD_ADD_MONTH, 1));
    push_cmd(make_add(CMD_ADD_DAY, 30));      // 3 march plus 30, carry into april
    push_cmd(make_set(31, 12, 2000));
    push_cmd(make_add(CMD_ADD_DAY, 30));      // carry into the next year
    push_cmd(make_set(31, 12, 9999));
    push_cmd(make_add(CMD_ADD_DAY, 1));       // year overflow on the day carry
    push_cmd(make_add(CMD_ADD_MONTH, 1));
    push_cmd(make_add(CMD_ADD_YEAR, 0));
    push_cmd(make_set(29, 2, 2012));
    push_cmd(make_add(CMD_ADD_YEAR, 1));      // leap day to 1 march
    push_cmd(make_set(29, 2, 2012));
    push_cmd(make_add(CMD_ADD_YEAR, 4));
    push_cmd(make_add(CMD_ADD_MONTH, 4095));
    push_cmd(make_add(CMD_ADD_YEAR, 4095));
    push_cmd(make_add(CMD_ADD_YEAR, 4095));   // overflow
  endtask

  // default registers at their extremes, masking and the unused index
  task automatic test_defaults();
    write_default(CFG_IDX_DEFAULT_DAY, 14'h3FFF);   // masks down to 31
    write_default(CFG_IDX_DEFAULT_MONTH, 14'd12);
    write_default(CFG_IDX_DEFAULT_YEAR, 14'd9999);
    push_cmd(make_set(0, 0, 0));
    write_default(CFG_IDX_DEFAULT_MONTH, 14'd2);
    write_default(CFG_IDX_DEFAULT_YEAR, 14'd2013);
    push_cmd(make_set(0, 0, 0));                     // 31 february
    write_default(CFG_IDX_DEFAULT_DAY, 14'd0);
    push_cmd(make_set(0, 5, 2000));
    write_default(CFG_IDX_DEFAULT_DAY, 14'd1);
    write_default(CFG_IDX_DEFAULT_MONTH, 14'h3FFF); // month 15
    push_cmd(make_set(0, 0, 0));
    write_default(CFG_IDX_DEFAULT_MONTH, 14'd1);
    write_default(CFG_IDX_DEFAULT_YEAR, 14'd0);
    push_cmd(make_set(0, 0, 0));
    write_default(CFG_IDX_DEFAULT_YEAR, 14'h3FFF);
    push_cmd(make_set(0, 0, 0));
    write_default(CFG_IDX_DEFAULT_YEAR, 14'd1);
    write_default(CFG_IDX_UNUSED, 14'h3FFF);
    push_cmd(make_set(0, 0, 0));
  endtask

  // fresh defaults, now and then one out of range
  task automatic randomize_defaults();
    int unsigned r;
    r = $urandom_range(99);
    write_default(CFG_IDX_DEFAULT_DAY,
                  (r < 10) ? 14'($urandom_range(16383)) : 14'($urandom_range(1, 28)));
    write_default(CFG_IDX_DEFAULT_MONTH,
                  (r >= 90) ? 14'($urandom_range(16383)) : 14'($urandom_range(1, 12)));
    write_default(CFG_IDX_DEFAULT_YEAR,
                  (r >= 10 && r < 20) ? 14'($urandom_range(16383))
                                      : 14'($urandom_range(1, 9999)));
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned snd_pct,
                                     input int unsigned rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (i != 0 && i % 50 == 0)
        randomize_defaults();
      push_cmd(random_cmd());
    end
    settle_results();
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks <= hold_asks + 1;
    for (int i = 0; i < 24; i++)
      push_cmd(random_cmd());
    settle_results();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_cmd       <= CMD_SET;
    in_set_day   <= '0;
    in_set_month <= '0;
    in_set_year  <= '0;
    in_amount    <= '0;
    out_ready    <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_IDX_DEFAULT_DAY;
    cfg_wdata    <= '0;
    mismatches    = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks     = 0;
    hold_seen     = 0;
    hold_left     = 0;
    cal.day            = RST_DAY;
    cal.month          = RST_MONTH;
    cal.year           = RST_YEAR;
    dflt.default_day   = RST_DAY;
    dflt.default_month = RST_MONTH;
    dflt.default_year  = RST_YEAR;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_date();
    test_set_extremes();
    test_add_extremes();
    test_defaults();
    test_random_traffic(200, 34, 51);
    test_output_stall();
    test_random_traffic(200, 51, 34);
    test_random_traffic(200, 0, 0);

    settle_results();
    if (mismatches == 0 && pending_dates.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/cdr_pkg.sv
hw/rtl/cdr_cfg_regs.sv
hw/rtl/cdr_date_calc.sv
hw/rtl/calendar_date_register.sv
verif/tb_calendar_date_register.sv
